/* rtl/ssnds_pkg.sv */
package ssnds_pkg;

    typedef enum logic [1:0] {
        FUNC_NUMBER = 2'd0,
        FUNC_TEXT   = 2'd1,
        FUNC_SCAN   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_PREP  = 2'd1,
        ST_DIGIT = 2'd2
    } t_state;

    localparam logic [1:0] REG_DECIMAL_PLACES = 2'd0;
    localparam logic [1:0] REG_DOT_MASK       = 2'd1;
    localparam logic [1:0] REG_LED_BITS       = 2'd2;

    localparam int MAG_W       = 14;
    localparam int QUOT_W      = 11;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;

    localparam logic [MAG_W-1:0]   MAG_MAX_POS = 14'd9999;
    localparam logic [MAG_W-1:0]   MAG_MAX_NEG = 14'd999;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 13'd6554;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_BLANK = 7'h20;

    localparam logic [7:0] SEG_TABLE [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4,
        8'hFE, 8'hF6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hEE, 8'h00, 8'h9C, 8'h00, 8'h9E, 8'h8E, 8'h00,
        8'h6E, 8'h00, 8'h78, 8'h00, 8'h1C, 8'h00, 8'h00, 8'h00,
        8'hCE, 8'h00, 8'h00, 8'hB6, 8'h8C, 8'h7C, 8'h00, 8'h00,
        8'h00, 8'h00, 8'hDA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h3E, 8'h1A, 8'h7A, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h98, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h3A,
        8'h00, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h38, 8'h00,
        8'h00, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] char_seg(input logic [6:0] ch, input logic point);
        char_seg = {SEG_TABLE[ch][7:1], point};
    endfunction

endpackage

/* rtl/seven_segment_number_display_scan.sv */
// Channel   Dir  Bits                 Contents (lowest bit first)
// s_axis    in   tdata 64, tuser 2    number_value[31:0], text_char0..3; func
// m_axis    out  tdata 16             shift_word
// cfg       in   idx 2, data 4        decimal_places, dot_mask, led_bits
//
// set_text and scan_tick complete on acceptance; set_number goes through accept, clamp,
// then one digit per cycle through the shared divide-by-ten multiplier.
// A scan_tick result sits in the output register; a new item is taken while idle
// once that register is empty or being drained in the same cycle.
// Reset is synchronous, active low, and blanks the display.
module seven_segment_number_display_scan #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // number_value[31:0], text_char0..3 [59:32], pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // shift_word
);

    localparam int PH_W = $clog2(DIGIT_COUNT + 1);

    ssnds_pkg::t_state r_state, n_state;
    logic [2:0]  r_dp;
    logic [3:0]  r_dot, r_led;
    logic [7:0]  r_seg [4];
    logic [7:0]  n_seg [4];
    logic [PH_W-1:0] r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_word, n_out_word;
    logic [31:0] r_bits, n_bits;
    logic        r_neg, n_neg;
    logic [ssnds_pkg::MAG_W-1:0] r_mag, n_mag;
    logic [1:0]  r_step, n_step;

    logic        accept;
    logic [3:0]  ph_ext;
    logic [31:0] abs_val;
    logic [ssnds_pkg::MAG_W+ssnds_pkg::RECIP_W-1:0] prod;
    logic [ssnds_pkg::QUOT_W-1:0] quot;
    logic [ssnds_pkg::MAG_W-1:0]  rem_full;
    logic [2:0]  fill;
    logic [6:0]  ch;
    logic        point;
    logic        ended;
    logic [6:0]  tch;
    logic [7:0]  sel;

    assign s_axis_tready = (r_state == ssnds_pkg::ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

    assign ph_ext   = 4'(r_phase);
    assign abs_val  = r_bits[31] ? (32'd0 - r_bits) : r_bits;
    assign prod     = r_mag * ssnds_pkg::RECIP_TEN;
    assign quot     = prod[ssnds_pkg::RECIP_SHIFT +: ssnds_pkg::QUOT_W];
    assign rem_full = r_mag - (ssnds_pkg::MAG_W'(quot) * ssnds_pkg::MAG_W'(10));
    assign fill     = (r_dp <= 3'd4) ? r_dp : 3'd0;

    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_word  = r_out_word;
        n_bits      = r_bits;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_step      = r_step;
        ch          = ssnds_pkg::CHAR_BLANK;
        point       = 1'b0;
        ended       = 1'b0;
        tch         = ssnds_pkg::CHAR_BLANK;
        sel         = 8'd0;
        unique case (r_state)
            ssnds_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (ssnds_pkg::t_func'(s_axis_tuser))
                        ssnds_pkg::FUNC_NUMBER: begin
                            n_bits  = s_axis_tdata[31:0];
                            n_state = ssnds_pkg::ST_PREP;
                        end
                        ssnds_pkg::FUNC_TEXT: begin
                            for (int k = 0; k < 4; k++) begin
                                tch = s_axis_tdata[32 + 7*k +: 7];
                                if (tch == 7'd0) begin
                                    ended = 1'b1;
                                end
                                n_seg[k] = ssnds_pkg::char_seg(
                                    ended ? ssnds_pkg::CHAR_BLANK : tch, r_dot[3-k]);
                            end
                        end
                        ssnds_pkg::FUNC_SCAN: begin
                            n_out_valid = 1'b1;
                            if (ph_ext < 4'(DIGIT_COUNT)) begin
                                sel        = 8'd1 << ph_ext[2:0];
                                n_out_word = {(ph_ext < 4'd4) ? r_seg[ph_ext[1:0]] : 8'd0,
                                              sel | {r_led, 4'd0}};
                                n_phase    = r_phase + PH_W'(1);
                            end else begin
                                n_out_word = 16'd0;
                                n_phase    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ssnds_pkg::ST_PREP: begin
                n_neg  = r_bits[31];
                n_step = 2'd0;
                if (r_bits[31]) begin
                    n_mag = (abs_val >= 32'(ssnds_pkg::MAG_MAX_NEG)) ?
                            ssnds_pkg::MAG_MAX_NEG : abs_val[ssnds_pkg::MAG_W-1:0];
                end else begin
                    n_mag = (abs_val >= 32'(ssnds_pkg::MAG_MAX_POS)) ?
                            ssnds_pkg::MAG_MAX_POS : abs_val[ssnds_pkg::MAG_W-1:0];
                end
                n_state = ssnds_pkg::ST_DIGIT;
            end
            ssnds_pkg::ST_DIGIT: begin
                if (r_mag != '0) begin
                    ch    = ssnds_pkg::CHAR_ZERO + 7'(rem_full[3:0]);
                    n_mag = ssnds_pkg::MAG_W'(quot);
                end else if (3'(r_step) < fill) begin
                    ch = ssnds_pkg::CHAR_ZERO;
                end else if (r_neg) begin
                    ch    = ssnds_pkg::CHAR_MINUS;
                    n_neg = 1'b0;
                end
                point = ((r_dp != 3'd0) && (r_dp <= 3'd4) && (3'(r_step) == r_dp - 3'd1))
                        || r_dot[r_step];
                n_seg[2'd3 - r_step] = ssnds_pkg::char_seg(ch, point);
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = ssnds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssnds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssnds_pkg::ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_dp        <= 3'd0;
            r_dot       <= 4'd0;
            r_led       <= 4'd0;
            for (int k = 0; k < 4; k++) begin
                r_seg[k] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_seg       <= n_seg;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ssnds_pkg::REG_DECIMAL_PLACES: r_dp  <= i_cfg_data[2:0];
                    ssnds_pkg::REG_DOT_MASK:       r_dot <= i_cfg_data;
                    ssnds_pkg::REG_LED_BITS:       r_led <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_bits     <= n_bits;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_step     <= n_step;
    end

endmodule

/* rtl/ssnds_chk.sv */
module ssnds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // hold a pending result until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transaction");

    // stay busy after a number is taken
    a_number_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ssnds_pkg::FUNC_NUMBER)
        |=> !s_axis_tready)
        else $error("ready while digits are extracted");

    // present a word after every scan tick
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ssnds_pkg::FUNC_SCAN)
        |=> m_axis_tvalid)
        else $error("scan tick without result");

    // a nonblank word always selects a digit
    a_word_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata != 16'd0) |-> (m_axis_tdata[7:0] != 8'd0))
        else $error("word without digit select");

endmodule

bind seven_segment_number_display_scan ssnds_chk u_ssnds_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
